// File: hw/rtl/euwc_pkg.sv
package euwc_pkg;

	// Default memory size in bytes
	localparam int unsigned MEM_DEPTH_DEF = 1024;

	// Fixed field widths
	localparam int unsigned ADDR_W  = 10;
	localparam int unsigned TICKS_W = 16;

	// Reset value of the write duration register
	localparam logic [TICKS_W-1:0] WRITE_TICKS_RST = 16'd4;

	// Unlock keys and erased byte value
	localparam logic [7:0] UNLOCK_KEY1 = 8'h55;
	localparam logic [7:0] UNLOCK_KEY2 = 8'hAA;
	localparam logic [7:0] ERASED_BYTE = 8'hFF;

	// Operation codes
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Register map
	localparam logic [2:0] REG_ADDR_HI = 3'd0;
	localparam logic [2:0] REG_ADDR_LO = 3'd1;
	localparam logic [2:0] REG_DATA    = 3'd2;
	localparam logic [2:0] REG_CONTROL = 3'd3;
	localparam logic [2:0] REG_UNLOCK  = 3'd4;

	// Control register bit positions
	localparam int unsigned CTL_PM_BIT   = 7;
	localparam int unsigned CTL_CFG_BIT  = 6;
	localparam int unsigned CTL_WREN_BIT = 2;
	localparam int unsigned CTL_WR_BIT   = 1;
	localparam int unsigned CTL_RD_BIT   = 0;

	typedef enum logic [1:0] {
		UNL_LOCKED,
		UNL_KEY1_SEEN,
		UNL_OPEN
	} unlock_t;

	typedef struct packed {
		logic pm_sel;
		logic cfg_sel;
		logic wr_en;
	} control_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [2:0] reg_select;
		logic [7:0] write_value;
	} item_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       busy_res;
		logic       write_done;
	} result_t;

endpackage

// File: hw/rtl/eeprom_unlock_write_controller.sv
// Data EEPROM controller with a 0x55 / 0xAA unlock sequence.
//
// Items: an item word (register read, register write or time tick) is taken
// at a rising edge with start high and busy low. One item is accepted every
// cycle while busy is low; each produces exactly one result word.
// Results: result_valid is high for one cycle with the result word; the
// receiver must take it then. An accepted item is registered in the input
// stage, then processed and its result captured in the result register,
// which drives the ports; a new item can be accepted while one is in flight.
// The single memory read port is read every cycle at the address that the
// next item will see, which is what allows one item per cycle.
// Config: cfg_data sets the byte write duration in ticks (0 acts as 1),
// written on cfg_valid && cfg_ready; cfg_ready is always high.
// Reset: arst_n clears the control and state registers and starts a clearing
// pass that writes 0xFF to every byte, one byte per cycle. busy is high
// during that pass and no items are taken; config writes still work.
// The receiver cannot stall, so there is no output back pressure.
module eeprom_unlock_write_controller
	import euwc_pkg::*;
#(
	parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  item_t              item,
	output logic               result_valid,
	output result_t            result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [TICKS_W-1:0] cfg_data
);

	localparam int unsigned AW = $clog2(MEM_DEPTH);
	localparam int unsigned RW = ADDR_W + 3;

	// Address to memory index: address modulo depth (for addresses below five times the depth), four compare-subtracts
	function automatic logic [AW-1:0] mem_idx(input logic [ADDR_W-1:0] a);
		logic [RW-1:0] t;
		t = {3'b000, a};
		for (int i = 0; i < 4; i++) begin
			if (t >= RW'(MEM_DEPTH)) begin
				t = t - RW'(MEM_DEPTH);
			end
		end
		return t[AW-1:0];
	endfunction

	// Storage
	logic [7:0] mem [MEM_DEPTH];
	logic [7:0] rd_q;

	// Clearing pass
	logic          clr_active_q;
	logic [AW-1:0] clr_addr_q;

	// Input stage
	logic  valid_s1;
	item_t item_s1;

	// Architectural state
	logic [ADDR_W-1:0]  addr_q, addr_d;
	logic [7:0]         data_q, data_d;
	control_t           ctrl_q, ctrl_d;
	unlock_t            unlock_q, unlock_d;
	logic [TICKS_W-1:0] cnt_q, cnt_d;
	logic               active_q, active_d;
	logic [TICKS_W-1:0] ticks_q;

	// Step outputs
	logic [7:0]    rd_val;
	logic          done;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;

	assign busy      = clr_active_q;
	assign cfg_ready = 1'b1;

	// Clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == AW'(MEM_DEPTH - 1)) begin
				clr_active_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= WRITE_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			ticks_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	// One item step: register access, control decode, tick countdown
	always_comb begin
		addr_d    = addr_q;
		data_d    = data_q;
		ctrl_d    = ctrl_q;
		unlock_d  = unlock_q;
		cnt_d     = cnt_q;
		active_d  = active_q;
		rd_val    = '0;
		done      = 1'b0;
		mem_we    = clr_active_q;
		mem_waddr = clr_addr_q;
		mem_wdata = ERASED_BYTE;
		if (valid_s1) begin
			case (item_s1.operation)
				OP_READ: begin
					case (item_s1.reg_select)
						REG_ADDR_HI: rd_val = {6'b000000, addr_q[ADDR_W-1:8]};
						REG_ADDR_LO: rd_val = addr_q[7:0];
						REG_DATA:    rd_val = data_q;
						REG_CONTROL: rd_val = {ctrl_q.pm_sel, ctrl_q.cfg_sel, 3'b000,
							ctrl_q.wr_en, active_q, 1'b0};
						default:     rd_val = '0;
					endcase
					unlock_d = UNL_LOCKED;
				end
				OP_WRITE: begin
					if (item_s1.reg_select == REG_UNLOCK) begin
						// Unlock sequence: 0x55 then 0xAA
						if (item_s1.write_value == UNLOCK_KEY1) begin
							unlock_d = UNL_KEY1_SEEN;
						end else if (item_s1.write_value == UNLOCK_KEY2 &&
							unlock_q == UNL_KEY1_SEEN) begin
							unlock_d = UNL_OPEN;
						end else begin
							unlock_d = UNL_LOCKED;
						end
					end else begin
						unlock_d = UNL_LOCKED;
						case (item_s1.reg_select)
							REG_CONTROL: begin
								ctrl_d.pm_sel  = item_s1.write_value[CTL_PM_BIT];
								ctrl_d.cfg_sel = item_s1.write_value[CTL_CFG_BIT];
								ctrl_d.wr_en   = item_s1.write_value[CTL_WREN_BIT];
								if (!active_q && !item_s1.write_value[CTL_PM_BIT] &&
									!item_s1.write_value[CTL_CFG_BIT]) begin
									if (item_s1.write_value[CTL_RD_BIT]) begin
										data_d = rd_q;
									end
									if (item_s1.write_value[CTL_WR_BIT] &&
										item_s1.write_value[CTL_WREN_BIT] &&
										unlock_q == UNL_OPEN) begin
										active_d = 1'b1;
										cnt_d    = (ticks_q == '0) ? TICKS_W'(1) : ticks_q;
									end
								end
							end
							REG_ADDR_HI: begin
								if (!active_q) begin
									addr_d[ADDR_W-1:8] = item_s1.write_value[1:0];
								end
							end
							REG_ADDR_LO: begin
								if (!active_q) begin
									addr_d[7:0] = item_s1.write_value;
								end
							end
							REG_DATA: begin
								if (!active_q) begin
									data_d = item_s1.write_value;
								end
							end
							default: ;
						endcase
					end
				end
				OP_TICK: begin
					if (active_q) begin
						cnt_d = cnt_q - 1'b1;
						if (cnt_q == TICKS_W'(1)) begin
							mem_we    = 1'b1;
							mem_waddr = mem_idx(addr_q);
							mem_wdata = data_q;
							active_d  = 1'b0;
							done      = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			data_q   <= '0;
			ctrl_q   <= '0;
			unlock_q <= UNL_LOCKED;
			cnt_q    <= '0;
			active_q <= 1'b0;
		end else begin
			addr_q   <= addr_d;
			data_q   <= data_d;
			ctrl_q   <= ctrl_d;
			unlock_q <= unlock_d;
			cnt_q    <= cnt_d;
			active_q <= active_d;
		end
	end

	// Memory: read ahead at the address the next item sees, with write bypass
	assign mem_raddr = mem_idx(addr_d);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && mem_waddr == mem_raddr) begin
			rd_q <= mem_wdata;
		end else begin
			rd_q <= mem[mem_raddr];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result.read_value <= rd_val;
			result.busy_res   <= active_d;
			result.write_done <= done;
		end
	end

	// Checks
	a_no_item_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !valid_s1)
		else $error("item in flight during clearing pass");

	a_active_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> cnt_q != '0)
		else $error("write active with zero count");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.write_done |-> !result.busy_res)
		else $error("write done reported while still busy");

	a_done_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.write_done |->
		$past(valid_s1 && item_s1.operation == OP_TICK && active_q))
		else $error("write done without a tick of an active write");

endmodule
